/* hw/rtl/cbmm_pkg.sv */
// ----------------------------------------------------------------------------
// cbmm_pkg
// Types and constants shared by the cell balance min/max controller.
// ----------------------------------------------------------------------------
`default_nettype none

package cbmm_pkg;

    localparam int CELL_W    = 6;
    localparam int MV_W      = 16;
    localparam int TEMP_W    = 12;
    localparam int CUR_W     = 12;
    localparam int THR_W     = 10;
    localparam int GAIN_W    = 8;
    localparam int GROUP_W   = 2;
    localparam int PROD_W    = GAIN_W + MV_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [MV_W-1:0] MIN_START_MV = 16'd5000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CUR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CUR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP  = 3'd4;

    localparam logic [THR_W-1:0]  RST_THRESHOLD = 10'd20;
    localparam logic [CUR_W-1:0]  RST_MIN_CUR   = 12'd500;
    localparam logic [CUR_W-1:0]  RST_MAX_CUR   = 12'd2000;
    localparam logic [GAIN_W-1:0] RST_GAIN      = 8'd10;
    localparam logic [TEMP_W-1:0] RST_MAX_TEMP  = 12'd750;

    typedef struct packed {
        logic [THR_W-1:0]  threshold_mv;
        logic [CUR_W-1:0]  min_current_ma;
        logic [CUR_W-1:0]  max_current_ma;
        logic [GAIN_W-1:0] gain_ma_per_mv;
        logic [TEMP_W-1:0] max_temp_deci_c;
    } cfg_t;

    // one finished scan, front to back
    typedef struct packed {
        logic [GROUP_W-1:0] group;
        logic               hot;
        logic               fault;
        logic [MV_W-1:0]    max_mv;
        logic [MV_W-1:0]    min_mv;
        logic [CELL_W-1:0]  max_pos;
        logic [CELL_W-1:0]  min_pos;
    } scan_rec_t;

endpackage

`default_nettype wire

/* hw/rtl/cbmm_front.sv */
// ----------------------------------------------------------------------------
// cbmm_front
// Scan unit: tracks running max/min of a group scan, emits a record on the
// last cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cbmm_front #(
    parameter int CELLS_PER_GROUP = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire cbmm_pkg::cfg_t                    cfg,
    input  wire logic                              in_accept,
    input  wire logic [cbmm_pkg::GROUP_W-1:0]      in_group,
    input  wire logic [cbmm_pkg::MV_W-1:0]         in_mv,
    input  wire logic                              in_last,
    input  wire logic [cbmm_pkg::TEMP_W-1:0]       in_temp,
    input  wire logic                              in_fault,
    output logic                                   rec_push,
    output cbmm_pkg::scan_rec_t                    rec
);

    localparam logic [cbmm_pkg::CELL_W-1:0] CPG6     = cbmm_pkg::CELL_W'(CELLS_PER_GROUP);
    localparam logic [cbmm_pkg::CELL_W-1:0] LAST_POS = cbmm_pkg::CELL_W'(CELLS_PER_GROUP - 1);

    logic [cbmm_pkg::MV_W-1:0]   run_max_reg, run_max_next;
    logic [cbmm_pkg::MV_W-1:0]   run_min_reg, run_min_next;
    logic [cbmm_pkg::CELL_W-1:0] max_pos_reg, max_pos_next;
    logic [cbmm_pkg::CELL_W-1:0] min_pos_reg, min_pos_next;
    logic [cbmm_pkg::CELL_W-1:0] cell_pos_reg, cell_pos_next;

    logic                        scan_start;
    logic [cbmm_pkg::CELL_W-1:0] base_cell;
    logic [cbmm_pkg::CELL_W-1:0] here;
    logic [cbmm_pkg::MV_W-1:0]   cur_max;
    logic [cbmm_pkg::MV_W-1:0]   cur_min;
    logic [cbmm_pkg::CELL_W-1:0] cur_max_pos;
    logic [cbmm_pkg::CELL_W-1:0] cur_min_pos;

    always_comb begin
        scan_start  = (cell_pos_reg == '0);
        base_cell   = cbmm_pkg::CELL_W'({{(cbmm_pkg::CELL_W-cbmm_pkg::GROUP_W){1'b0}}, in_group}
                      * CPG6);
        here        = base_cell + cell_pos_reg;
        cur_max     = scan_start ? '0 : run_max_reg;
        cur_min     = scan_start ? cbmm_pkg::MIN_START_MV : run_min_reg;
        cur_max_pos = scan_start ? base_cell : max_pos_reg;
        cur_min_pos = scan_start ? base_cell : min_pos_reg;

        run_max_next = cur_max;
        max_pos_next = cur_max_pos;
        if (in_mv > cur_max) begin
            run_max_next = in_mv;
            max_pos_next = here;
        end
        run_min_next = cur_min;
        min_pos_next = cur_min_pos;
        if (in_mv < cur_min) begin
            run_min_next = in_mv;
            min_pos_next = here;
        end

        if (in_last) begin
            cell_pos_next = '0;
        end else if (cell_pos_reg < LAST_POS) begin
            cell_pos_next = cell_pos_reg + 1'b1;
        end else begin
            cell_pos_next = cell_pos_reg;
        end

        rec_push      = in_accept && in_last;
        rec.group     = in_group;
        rec.hot       = $signed(in_temp) > $signed(cfg.max_temp_deci_c);
        rec.fault     = in_fault;
        rec.max_mv    = run_max_next;
        rec.min_mv    = run_min_next;
        rec.max_pos   = max_pos_next;
        rec.min_pos   = min_pos_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_pos_reg <= '0;
        end else if (in_accept) begin
            cell_pos_reg <= cell_pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            run_max_reg <= run_max_next;
            run_min_reg <= run_min_next;
            max_pos_reg <= max_pos_next;
            min_pos_reg <= min_pos_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/cbmm_queue.sv */
// ----------------------------------------------------------------------------
// cbmm_queue
// Small FIFO of scan records between the scan unit and the decision pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module cbmm_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire cbmm_pkg::scan_rec_t  push_rec,
    output logic                      not_full,
    input  wire logic                 pop,
    output logic                      not_empty,
    output cbmm_pkg::scan_rec_t       head
);

    cbmm_pkg::scan_rec_t mem [cbmm_pkg::QUEUE_DEPTH];

    logic [cbmm_pkg::QUEUE_AW-1:0] wr_ptr_reg;
    logic [cbmm_pkg::QUEUE_AW-1:0] rd_ptr_reg;
    logic [cbmm_pkg::QUEUE_AW:0]   count_reg, count_next;
    logic                          do_push;
    logic                          do_pop;

    always_comb begin
        not_full  = (count_reg != (cbmm_pkg::QUEUE_AW+1)'(cbmm_pkg::QUEUE_DEPTH));
        not_empty = (count_reg != '0);
        do_push   = push && not_full;
        do_pop    = pop && not_empty;
        head      = mem[rd_ptr_reg];
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/cbmm_back.sv */
// ----------------------------------------------------------------------------
// cbmm_back
// Decision pipe: delta and enable, gain multiply, add and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module cbmm_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire cbmm_pkg::cfg_t                cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire cbmm_pkg::scan_rec_t           in_rec,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [cbmm_pkg::GROUP_W-1:0]       out_group,
    output logic                               out_on,
    output logic                               out_hot,
    output logic [cbmm_pkg::CELL_W-1:0]        out_source,
    output logic [cbmm_pkg::CELL_W-1:0]        out_target,
    output logic [cbmm_pkg::MV_W-1:0]          out_delta,
    output logic [cbmm_pkg::CUR_W-1:0]         out_drive
);

    // stage 1: delta, excess, enable
    logic                          v1_reg;
    logic [cbmm_pkg::GROUP_W-1:0]  grp1_reg;
    logic                          on1_reg, hot1_reg;
    logic [cbmm_pkg::CELL_W-1:0]   src1_reg, tgt1_reg;
    logic [cbmm_pkg::MV_W-1:0]     delta1_reg, excess1_reg;
    // stage 2: product
    logic                          v2_reg;
    logic [cbmm_pkg::GROUP_W-1:0]  grp2_reg;
    logic                          on2_reg, hot2_reg;
    logic [cbmm_pkg::CELL_W-1:0]   src2_reg, tgt2_reg;
    logic [cbmm_pkg::MV_W-1:0]     delta2_reg;
    logic [cbmm_pkg::PROD_W-1:0]   prod2_reg;
    // output register
    logic                          v3_reg;
    logic [cbmm_pkg::GROUP_W-1:0]  grp3_reg;
    logic                          on3_reg, hot3_reg;
    logic [cbmm_pkg::CELL_W-1:0]   src3_reg, tgt3_reg;
    logic [cbmm_pkg::MV_W-1:0]     delta3_reg;
    logic [cbmm_pkg::CUR_W-1:0]    drive3_reg;

    logic                          en1, en2, en3;
    logic [cbmm_pkg::MV_W-1:0]     delta_next;
    logic [cbmm_pkg::MV_W-1:0]     thr16;
    logic                          on_next;
    logic [cbmm_pkg::SUM_W-1:0]    sum;
    logic [cbmm_pkg::CUR_W-1:0]    drive_next;

    always_comb begin
        en3      = !v3_reg || out_ready;
        en2      = !v2_reg || en3;
        en1      = !v1_reg || en2;
        in_ready = en1;

        thr16 = cbmm_pkg::MV_W'(cfg.threshold_mv);
        if (in_rec.min_mv >= cbmm_pkg::MIN_START_MV || in_rec.max_mv < in_rec.min_mv) begin
            delta_next = '0;
        end else begin
            delta_next = in_rec.max_mv - in_rec.min_mv;
        end
        on_next = !in_rec.hot && !in_rec.fault && (delta_next > thr16);

        sum = cbmm_pkg::SUM_W'(cfg.min_current_ma) + cbmm_pkg::SUM_W'(prod2_reg);
        if (!on2_reg) begin
            drive_next = '0;
        end else if (sum > cbmm_pkg::SUM_W'(cfg.max_current_ma)) begin
            drive_next = cfg.max_current_ma;
        end else begin
            drive_next = sum[cbmm_pkg::CUR_W-1:0];
        end

        out_valid  = v3_reg;
        out_group  = grp3_reg;
        out_on     = on3_reg;
        out_hot    = hot3_reg;
        out_source = src3_reg;
        out_target = tgt3_reg;
        out_delta  = delta3_reg;
        out_drive  = drive3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= in_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            grp1_reg    <= in_rec.group;
            on1_reg     <= on_next;
            hot1_reg    <= in_rec.hot;
            src1_reg    <= in_rec.max_pos;
            tgt1_reg    <= in_rec.min_pos;
            delta1_reg  <= delta_next;
            excess1_reg <= delta_next - thr16;
        end
        if (en2) begin
            grp2_reg   <= grp1_reg;
            on2_reg    <= on1_reg;
            hot2_reg   <= hot1_reg;
            src2_reg   <= src1_reg;
            tgt2_reg   <= tgt1_reg;
            delta2_reg <= delta1_reg;
            prod2_reg  <= cbmm_pkg::PROD_W'(cfg.gain_ma_per_mv) * cbmm_pkg::PROD_W'(excess1_reg);
        end
        if (en3) begin
            grp3_reg   <= grp2_reg;
            on3_reg    <= on2_reg;
            hot3_reg   <= hot2_reg;
            src3_reg   <= src2_reg;
            tgt3_reg   <= tgt2_reg;
            delta3_reg <= delta2_reg;
            drive3_reg <= drive_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/cell_balance_minmax_controller.sv */
// ----------------------------------------------------------------------------
// cell_balance_minmax_controller
// Max/min cell voltage tracker with active balancing decision per group scan.
// ----------------------------------------------------------------------------
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tdata cell, temp, fault; tuser group; tlast
// m_*       out  m_tvalid/m_tready   tdata decision; tuser group
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// One cell request per cycle while the record queue has room; the scan compare is combinational.
// After the last cell, a decision passes the record queue and the delta, multiply, saturate registers.
// A four-entry record queue decouples the scan from output stalls.
// Synchronous active-low reset clears control state and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_balance_minmax_controller #(
    parameter int CELLS_PER_GROUP = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // cell_mv[15:0], pcb_temp_deci_c[27:16],
                                        // emergency_fault[28], zero[31:29]
    input  wire logic [1:0]  s_tuser,   // group_id[1:0]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // balance_on[0], over_temp[1], donor_cell[7:2],
                                        // receiver_cell[13:8], delta_mv[29:14],
                                        // drive_current_ma[41:30], zero[47:42]
    output logic [1:0]       m_tuser,   // out_group[1:0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [11:0] cfg_data
);

    cbmm_pkg::cfg_t      cfg_reg;
    cbmm_pkg::scan_rec_t push_rec;
    cbmm_pkg::scan_rec_t head_rec;

    logic                               in_accept;
    logic                               rec_push;
    logic                               q_not_full;
    logic                               q_not_empty;
    logic                               back_ready;
    logic                               out_on, out_hot;
    logic [cbmm_pkg::CELL_W-1:0]        out_source, out_target;
    logic [cbmm_pkg::MV_W-1:0]          out_delta;
    logic [cbmm_pkg::CUR_W-1:0]         out_drive;

    assign cfg_ready = 1'b1;
    assign s_tready  = q_not_full;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold_mv    <= cbmm_pkg::RST_THRESHOLD;
            cfg_reg.min_current_ma  <= cbmm_pkg::RST_MIN_CUR;
            cfg_reg.max_current_ma  <= cbmm_pkg::RST_MAX_CUR;
            cfg_reg.gain_ma_per_mv  <= cbmm_pkg::RST_GAIN;
            cfg_reg.max_temp_deci_c <= cbmm_pkg::RST_MAX_TEMP;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                cbmm_pkg::REG_THRESHOLD: begin
                    cfg_reg.threshold_mv <= cfg_data[cbmm_pkg::THR_W-1:0];
                end
                cbmm_pkg::REG_MIN_CUR: begin
                    cfg_reg.min_current_ma <= cfg_data;
                end
                cbmm_pkg::REG_MAX_CUR: begin
                    cfg_reg.max_current_ma <= cfg_data;
                end
                cbmm_pkg::REG_GAIN: begin
                    cfg_reg.gain_ma_per_mv <= cfg_data[cbmm_pkg::GAIN_W-1:0];
                end
                cbmm_pkg::REG_MAX_TEMP: begin
                    cfg_reg.max_temp_deci_c <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    cbmm_front #(
        .CELLS_PER_GROUP (CELLS_PER_GROUP)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_accept (in_accept),
        .in_group  (s_tuser),
        .in_mv     (s_tdata[15:0]),
        .in_last   (s_tlast),
        .in_temp   (s_tdata[27:16]),
        .in_fault  (s_tdata[28]),
        .rec_push  (rec_push),
        .rec       (push_rec)
    );

    cbmm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_push),
        .push_rec  (push_rec),
        .not_full  (q_not_full),
        .pop       (back_ready),
        .not_empty (q_not_empty),
        .head      (head_rec)
    );

    cbmm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (q_not_empty),
        .in_ready   (back_ready),
        .in_rec     (head_rec),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_group  (m_tuser),
        .out_on     (out_on),
        .out_hot    (out_hot),
        .out_source (out_source),
        .out_target (out_target),
        .out_delta  (out_delta),
        .out_drive  (out_drive)
    );

    assign m_tdata = {6'd0, out_drive, out_delta, out_target, out_source, out_hot, out_on};

endmodule

`default_nettype wire
